FILE: hw/rtl/mxt_pkg.sv
// Shared types and constants for the max-extract table.
package mxt_pkg;

  // Default number of table slots
  localparam int unsigned TableDepthDef = 64;

  // Payload widths
  localparam int unsigned IdW    = 16;
  localparam int unsigned ScoreW = 32;
  // One stored entry: present mark, id, score (score in the low bits)
  localparam int unsigned EntryW = 1 + IdW + ScoreW;

  // Operation codes carried on the slave-side tuser
  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // Status codes carried on the master-side tuser
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_DONE     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  // One result transaction
  typedef struct packed {
    status_e                    status;
    logic [IdW-1:0]             found_id;
    logic signed [ScoreW-1:0]   found_score;
  } result_t;

endpackage

FILE: hw/rtl/mxt_mem.sv
// Entry memory: one write port, one read port, registered read data.
module mxt_mem
  import mxt_pkg::*;
#(
  parameter int unsigned Depth = TableDepthDef,
  parameter int unsigned Width = EntryW,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port: read data is registered and appears in the cycle after the read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/mxt_ctrl.sv
// Sequencer: insert, clear, and the linear scan that extracts the maximum.
module mxt_ctrl
  import mxt_pkg::*;
#(
  parameter int unsigned Depth = TableDepthDef,
  localparam int unsigned AddrW = $clog2(Depth),
  localparam int unsigned CntW  = $clog2(Depth + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Incoming transaction
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  op_e                      in_op_i,
  input  logic [IdW-1:0]           in_id_i,
  input  logic signed [ScoreW-1:0] in_score_i,
  // Memory port
  output logic                     mem_we_o,
  output logic [AddrW-1:0]         mem_waddr_o,
  output logic [EntryW-1:0]        mem_wdata_o,
  output logic                     mem_re_o,
  output logic [AddrW-1:0]         mem_raddr_o,
  input  logic [EntryW-1:0]        mem_rdata_i,
  // Result handoff
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output result_t                  res_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_LAST   = 5'b00100,
    S_WRBACK = 5'b01000,
    S_EMIT   = 5'b10000
  } state_e;

  state_e                   state_q, state_d;
  logic [CntW-1:0]          fill_q, fill_d;
  logic [AddrW-1:0]         scan_q, scan_d;
  logic                     rd_vld_q, rd_vld_d;
  logic [AddrW-1:0]         rd_idx_q, rd_idx_d;
  logic                     have_q, have_d;
  logic [AddrW-1:0]         best_idx_q, best_idx_d;
  logic [IdW-1:0]           best_id_q, best_id_d;
  logic signed [ScoreW-1:0] best_score_q, best_score_d;
  result_t                  res_q, res_d;

  // Fields of the entry coming back from memory
  logic                     rd_present;
  logic [IdW-1:0]           rd_id;
  logic signed [ScoreW-1:0] rd_score;

  assign rd_present = mem_rdata_i[EntryW-1];
  assign rd_id      = mem_rdata_i[ScoreW +: IdW];
  assign rd_score   = $signed(mem_rdata_i[ScoreW-1:0]);

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    scan_d       = scan_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = scan_q;
    have_d       = have_q;
    best_idx_d   = best_idx_q;
    best_id_d    = best_id_q;
    best_score_d = best_score_q;
    res_d        = res_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = fill_q[AddrW-1:0];
    mem_wdata_o  = {1'b1, in_id_i, in_score_i};
    mem_re_o     = 1'b0;
    mem_raddr_o  = scan_q;

    // Keep the running best; strict compare so the lowest slot wins ties
    if (rd_vld_q && rd_present && (!have_q || (rd_score > best_score_q))) begin
      have_d       = 1'b1;
      best_idx_d   = rd_idx_q;
      best_id_d    = rd_id;
      best_score_d = rd_score;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_op_i)
            OP_INSERT: begin
              state_d = S_EMIT;
              res_d   = '{status: ST_INSERTED, found_id: '0, found_score: '0};
              if (fill_q == CntW'(Depth)) begin
                res_d.status = ST_FULL;
              end else begin
                mem_we_o = 1'b1;
                fill_d   = fill_q + CntW'(1);
              end
            end
            OP_EXTRACT: begin
              if (fill_q == '0) begin
                res_d   = '{status: ST_EMPTY, found_id: '0, found_score: '0};
                state_d = S_EMIT;
              end else begin
                scan_d  = '0;
                have_d  = 1'b0;
                state_d = S_SCAN;
              end
            end
            OP_CLEAR: begin
              fill_d  = '0;
              res_d   = '{status: ST_DONE, found_id: '0, found_score: '0};
              state_d = S_EMIT;
            end
            default: begin
              // Unused code: drop without a result
            end
          endcase
        end
      end
      S_SCAN: begin
        // Issue one read a cycle over the filled slots
        mem_re_o = 1'b1;
        rd_vld_d = 1'b1;
        rd_idx_d = scan_q;
        scan_d   = scan_q + AddrW'(1);
        if (CntW'(scan_q) == fill_q - CntW'(1)) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        // Last read data is folded in at this edge
        state_d = S_WRBACK;
      end
      S_WRBACK: begin
        if (have_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = best_idx_q;
          mem_wdata_o = {1'b0, best_id_q, best_score_q};
          res_d       = '{status: ST_DONE, found_id: best_id_q, found_score: best_score_q};
        end else begin
          res_d = '{status: ST_EMPTY, found_id: '0, found_score: '0};
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= '0;
      rd_vld_q <= 1'b0;
      have_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      rd_vld_q <= rd_vld_d;
      have_q   <= have_d;
    end
  end

  // Payload and scan bookkeeping
  always_ff @(posedge clk_i) begin
    scan_q       <= scan_d;
    rd_idx_q     <= rd_idx_d;
    best_idx_q   <= best_idx_d;
    best_id_q    <= best_id_d;
    best_score_q <= best_score_d;
    res_q        <= res_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_EMIT);
  assign res_o       = res_q;

endmodule

FILE: hw/rtl/max_extract_table.sv
// Top level of the max-extract table: stream ports, sequencer, memory, output register.
//
//   channel  dir  tdata (low bit up)           tuser
//   s_axis   in   entry_id[15:0], score[31:0]  operation[1:0]
//   m_axis   out  found_id[15:0],              status[1:0]
//                 found_score[31:0]
//
// Insert, clear, full and empty-table results pass through the sequencer's result
// register and then the output register. An extract first runs the scan, which
// reads every filled slot once through the single memory read port.
// Reset empties the table through the fill count; memory contents are kept.
// A result waits in the output register under m_axis_tready low while the
// next transaction is accepted; it then holds in the sequencer until taken.
module max_extract_table
  import mxt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef,
  localparam int unsigned AddrW = $clog2(TABLE_DEPTH)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // entry_id[15:0], score[47:16]
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // found_id[15:0], found_score[47:16]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [EntryW-1:0] mem_wdata;
  logic              mem_re;
  logic [AddrW-1:0]  mem_raddr;
  logic [EntryW-1:0] mem_rdata;
  logic              res_valid;
  logic              res_ready;
  result_t           res;
  logic              out_valid_q, out_valid_d;
  result_t           out_q;

  mxt_ctrl #(
    .Depth (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (op_e'(s_axis_tuser)),
    .in_id_i     (s_axis_tdata[IdW-1:0]),
    .in_score_i  ($signed(s_axis_tdata[IdW +: ScoreW])),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  mxt_mem #(
    .Depth (TABLE_DEPTH),
    .Width (EntryW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Load the output register when it is empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.found_score, out_q.found_id};
  assign m_axis_tuser  = out_q.status;

endmodule

FILE: verif/tb_max_extract_table.sv
// Self-checking testbench for the max-extract table: directed and random stream traffic.
module tb_max_extract_table;
  import mxt_pkg::*;

  // Score distributions used by the random sessions
  typedef enum int unsigned {
    SC_WIDE,
    SC_NARROW,
    SC_EDGE
  } score_mode_e;

  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned DrainLimit    = 20000;
  localparam int unsigned SettleCycles  = 100;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;   // entry_id[15:0], score[47:16]
  logic [1:0]  s_axis_tuser  = '0;   // operation[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;         // found_id[15:0], found_score[47:16]
  logic [1:0]  m_axis_tuser;         // status[1:0]

  // Flow control shared by sender and receiver
  logic        steady_flow = 1'b0;
  logic        hold_ask    = 1'b0;
  logic        hold_seen   = 1'b0;
  int unsigned hold_left   = 0;

  // Shadow copy of the table
  logic signed [ScoreW-1:0] shadow_score [TableDepthDef];
  logic [IdW-1:0]           shadow_id    [TableDepthDef];
  bit                       shadow_live  [TableDepthDef];
  int unsigned              shadow_used  = 0;

  result_t     expected_results [$];
  int unsigned err_count   = 0;
  int unsigned n_inserted  = 0;
  int unsigned n_dropped   = 0;
  int unsigned n_extracted = 0;
  int unsigned n_empty     = 0;
  int unsigned n_cleared   = 0;
  int unsigned n_ignored   = 0;

  max_extract_table DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // Compute the result of one operation and update the shadow table
  function automatic bit predict_table_op(input op_e op, input logic [IdW-1:0] id,
                                          input logic signed [ScoreW-1:0] score,
                                          output result_t res);
    int unsigned slot;
    int unsigned best;
    bit          have;
    res  = '0;
    best = 0;
    have = 1'b0;
    case (op)
      OP_INSERT: begin
        if (shadow_used >= TableDepthDef) begin
          res.status = ST_FULL;
          n_dropped++;
        end else begin
          shadow_score[shadow_used] = score;
          shadow_id[shadow_used]    = id;
          shadow_live[shadow_used]  = 1'b1;
          shadow_used++;
          res.status = ST_INSERTED;
          n_inserted++;
        end
      end
      OP_EXTRACT: begin
        // Strict compare keeps the earliest slot on equal scores
        for (slot = 0; slot < shadow_used; slot++) begin
          if (shadow_live[slot] && (!have || shadow_score[slot] > shadow_score[best])) begin
            best = slot;
            have = 1'b1;
          end
        end
        if (!have) begin
          res.status = ST_EMPTY;
          n_empty++;
        end else begin
          shadow_live[best] = 1'b0;
          res.status      = ST_DONE;
          res.found_id    = shadow_id[best];
          res.found_score = shadow_score[best];
          n_extracted++;
        end
      end
      OP_CLEAR: begin
        for (slot = 0; slot < TableDepthDef; slot++) shadow_live[slot] = 1'b0;
        shadow_used = 0;
        res.status  = ST_DONE;
        n_cleared++;
      end
      default: begin
        n_ignored++;
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  // Offer one transaction, wait for acceptance, and queue its expected result if it has one
  task automatic send_table_op(input op_e op, input logic [IdW-1:0] id,
                               input logic signed [ScoreW-1:0] score);
    result_t res;
    if (!steady_flow && $urandom_range(0, 99) < 11) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {score, id};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_table_op(op, id, score, res)) begin
      expected_results.insert(expected_results.size(), res);
    end
  endtask

  function automatic logic signed [ScoreW-1:0] pick_score(input score_mode_e mode);
    case (mode)
      SC_NARROW: return $signed(ScoreW'($urandom_range(0, 6))) - 3;
      SC_EDGE: begin
        case ($urandom_range(0, 4))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return 32'sh0000_0000;
          3:       return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic logic [IdW-1:0] pick_id();
    return IdW'($urandom_range(0, 65535));
  endfunction

  // Drive the result ready: random stalls, steady stretches, long hold-off on request
  always @(posedge clk_i) begin
    if (hold_ask != hold_seen) begin
      hold_seen     <= hold_ask;
      hold_left     <= HoldOffCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (steady_flow) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= 11);
    end
  end

  // Compare each accepted result against the oldest expectation
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d id %0h score %0h",
               m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[47:16]);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          err_count++;
        end
        if (m_axis_tdata[15:0] !== want.found_id) begin
          $error("found_id: expected %0h, got %0h", want.found_id, m_axis_tdata[15:0]);
          err_count++;
        end
        if (m_axis_tdata[47:16] !== want.found_score) begin
          $error("found_score: expected %0d, got %0d", want.found_score,
                 $signed(m_axis_tdata[47:16]));
          err_count++;
        end
      end
    end
  end

  // Extract and clear on a fresh table, plus the unused operation code
  task automatic test_empty_and_idle_ops();
    send_table_op(OP_EXTRACT, pick_id(), pick_score(SC_WIDE));
    send_table_op(OP_CLEAR, pick_id(), pick_score(SC_WIDE));
    send_table_op(OP_NONE, 16'hFFFF, 32'shFFFF_FFFF);
  endtask

  // Field extremes; equal top scores come out in load order
  task automatic test_extreme_entries();
    send_table_op(OP_INSERT, 16'hFFFF, 32'sh7FFF_FFFF);
    send_table_op(OP_INSERT, 16'h0000, 32'sh8000_0000);
    send_table_op(OP_INSERT, 16'h5A5A, -32'sd1);
    send_table_op(OP_INSERT, 16'hA5A5, 32'sh7FFF_FFFF);
    send_table_op(OP_INSERT, 16'h0001, 32'sh0000_0000);
    repeat (6) send_table_op(OP_EXTRACT, pick_id(), pick_score(SC_WIDE));
  endtask

  // Ties, an ignored item mid-sequence, and a clear that empties the table
  task automatic test_equal_scores_and_clear();
    send_table_op(OP_CLEAR, 16'h0000, 32'sh0000_0000);
    send_table_op(OP_INSERT, 16'd10, 32'sd5);
    send_table_op(OP_INSERT, 16'd20, 32'sd5);
    send_table_op(OP_INSERT, 16'd30, 32'sd5);
    send_table_op(OP_INSERT, 16'd40, 32'sd7);
    send_table_op(OP_NONE, 16'd99, 32'sd100);
    send_table_op(OP_EXTRACT, 16'h0000, 32'sh0000_0000);
    send_table_op(OP_EXTRACT, 16'h0000, 32'sh0000_0000);
    send_table_op(OP_CLEAR, 16'h0000, 32'sh0000_0000);
    send_table_op(OP_EXTRACT, 16'h0000, 32'sh0000_0000);
    send_table_op(OP_INSERT, 16'h1234, -32'sd5);
    send_table_op(OP_EXTRACT, 16'h0000, 32'sh0000_0000);
  endtask

  // Fill every slot, overflow it, then drain it, with no idling on either side
  task automatic test_full_table();
    steady_flow <= 1'b1;
    send_table_op(OP_CLEAR, pick_id(), pick_score(SC_WIDE));
    repeat (TableDepthDef) send_table_op(OP_INSERT, pick_id(), pick_score(SC_NARROW));
    repeat (2) send_table_op(OP_INSERT, pick_id(), pick_score(SC_WIDE));
    repeat (TableDepthDef + 1) send_table_op(OP_EXTRACT, pick_id(), pick_score(SC_WIDE));
    // Freed slots stay used until a clear
    send_table_op(OP_INSERT, pick_id(), pick_score(SC_WIDE));
    steady_flow <= 1'b0;
  endtask

  // Hold the result side off while transactions keep coming
  task automatic test_output_backpressure();
    hold_ask <= ~hold_ask;
    send_table_op(OP_CLEAR, pick_id(), pick_score(SC_WIDE));
    repeat (16) send_table_op(OP_INSERT, pick_id(), pick_score(SC_WIDE));
    repeat (6) send_table_op(OP_EXTRACT, pick_id(), pick_score(SC_WIDE));
  endtask

  // Sessions of inserts, extracts and clears with random content, some noise
  task automatic test_random_sessions(input int unsigned item_goal);
    int unsigned sent;
    int unsigned n_ops;
    int unsigned grow;
    int unsigned roll;
    score_mode_e mode;
    sent = 0;
    while (sent < item_goal) begin
      mode = score_mode_e'($urandom_range(0, 2));
      if ($urandom_range(0, 9) < 8) begin
        send_table_op(OP_CLEAR, pick_id(), pick_score(SC_WIDE));
        sent++;
      end
      n_ops = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(3, 30);
      grow  = $urandom_range(40, 75);
      repeat (n_ops) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          send_table_op(OP_NONE, pick_id(), pick_score(SC_WIDE));
        end else begin
          if (roll < grow) send_table_op(OP_INSERT, pick_id(), pick_score(mode));
          else if (roll < 97) send_table_op(OP_EXTRACT, pick_id(), pick_score(SC_WIDE));
          else send_table_op(OP_CLEAR, pick_id(), pick_score(SC_WIDE));
          sent++;
        end
      end
    end
  endtask

  // Reset, run the tests, drain and report
  initial begin
    int unsigned drain_cycles;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_idle_ops();
    test_extreme_entries();
    test_equal_scores_and_clear();
    test_full_table();
    test_output_backpressure();
    test_random_sessions(1700);
    s_axis_tvalid <= 1'b0;
    drain_cycles = 0;
    while (expected_results.size() != 0 && drain_cycles < DrainLimit) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      err_count++;
    end
    $display("covered: %0d inserts, %0d dropped on full, %0d extracts, %0d on empty",
             n_inserted, n_dropped, n_extracted, n_empty);
    $display("covered: %0d clears, %0d ignored items, %0d errors",
             n_cleared, n_ignored, err_count);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #1_500_000;
    $error("timeout");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
